>>> sv/slsc_pkg.sv
// Shared types and constants for the shell line syntax checker.
// No dependencies; imported by slsc_step and shell_line_syntax_check.
`timescale 1ns / 1ps

package slsc_pkg;

    // character codes
    localparam logic [7:0] CH_EOL  = 8'h00;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_DQ   = 8'h22;
    localparam logic [7:0] CH_SQ   = 8'h27;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_PIPE = 8'h7C;

    // open quote
    localparam logic [1:0] Q_NONE   = 2'd0;
    localparam logic [1:0] Q_SINGLE = 2'd1;
    localparam logic [1:0] Q_DOUBLE = 2'd2;

    // redirection run
    localparam logic [1:0] R_NONE = 2'd0;
    localparam logic [1:0] R_IN   = 2'd1;
    localparam logic [1:0] R_OUT  = 2'd2;

    localparam logic [1:0] RUN_MAX = 2'd2;
    localparam logic [1:0] RUN_SAT = 2'd3;

    // verdict codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_QUOTE = 2'd1;
    localparam logic [1:0] ERR_PIPE  = 2'd2;
    localparam logic [1:0] ERR_REDIR = 2'd3;

    typedef struct packed {
        logic [1:0] quote_mode;
        logic       seen_text;
        logic       pipe_wait;
        logic [1:0] redir_kind;
        logic [1:0] redir_count;
        logic       redir_gap;
        logic       pipe_fault;
        logic       redir_fault;
    } t_state;

    typedef struct packed {
        logic       eol;
        logic       line_ok;
        logic [1:0] error_kind;
    } t_verdict;

endpackage

>>> sv/shell_line_syntax_check.sv
// Shell command line syntax checker, top level.
// Depends on slsc_pkg and slsc_step.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_line_byte) takes one byte of a
//   command line per transfer. A zero byte ends the line. Every other byte
//   only updates the scan state and yields nothing.
//   Output channel (o_out_valid / i_out_stall / o_line_ok / o_error_kind)
//   carries one verdict per line: error_kind 0 none, 1 unclosed quote,
//   2 bad pipe, 3 bad redirection; line_ok is 1 only for kind 0.
// Throughput: one byte per cycle, sustained, including back-to-back lines, while the output is not stalled.
// Path: a terminating byte goes from the input register through the scan logic
//   into the verdict register, where its verdict is shown at the output.
// Stall: while a verdict waits in the output register, ordinary bytes keep
//   flowing; only the next terminating byte is held in the input register,
//   and the input stalls until the verdict is taken.
// Reset (i_rst_n low, synchronous): scan state cleared, both registers empty.
`timescale 1ns / 1ps

module shell_line_syntax_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_line_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_line_ok,
    output logic [1:0] o_error_kind
);
    import slsc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_state     r_state;
    t_state     n_state;
    t_verdict   verdict;
    logic       r_out_valid;
    logic       r_line_ok;
    logic [1:0] r_error_kind;
    logic       out_free;
    logic       advance;
    logic       in_take;

    slsc_step u_step (
        .i_state   (r_state),
        .i_byte    (r_in_byte),
        .o_next    (n_state),
        .o_verdict (verdict)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    // a byte leaves the input register unless it is a line end facing a full, stalled output
    assign advance    = r_in_valid && (!verdict.eol || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_line_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && verdict.eol) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && verdict.eol) begin
            r_line_ok    <= verdict.line_ok;
            r_error_kind <= verdict.error_kind;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_line_ok    = r_line_ok;
    assign o_error_kind = r_error_kind;

    // a fresh verdict comes only from a line end that just left the input register
    a_verdict_from_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid && r_in_byte == CH_EOL))
        else $error("verdict without a line end");

    a_ok_matches_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_line_ok == (r_error_kind == ERR_NONE)))
        else $error("line_ok disagrees with error_kind");

    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && verdict.eol) |=> (r_state == '0))
        else $error("scan state not cleared after line end");

    a_run_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.redir_kind == R_NONE) |->
            (r_state.redir_count == 2'd0 && !r_state.redir_gap))
        else $error("redirection run fields set with no run open");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held line end lost");

endmodule

>>> sv/slsc_step.sv
// Next-state and verdict logic for one line byte.
// Depends on slsc_pkg.
`timescale 1ns / 1ps

module slsc_step (
    input  slsc_pkg::t_state   i_state,
    input  logic [7:0]         i_byte,
    output slsc_pkg::t_state   o_next,
    output slsc_pkg::t_verdict o_verdict
);
    import slsc_pkg::*;

    logic       quoted;
    logic       blank;
    logic       pf;
    logic       rf;
    logic [7:0] run_ch;

    assign quoted = (i_state.quote_mode != Q_NONE);
    assign blank  = (i_byte == CH_SP) || (i_byte == CH_TAB) || (i_byte == CH_NL);
    assign run_ch = (i_state.redir_kind == R_IN) ? CH_LT : CH_GT;

    always_comb begin
        o_next               = i_state;
        o_verdict.eol        = 1'b0;
        o_verdict.line_ok    = 1'b0;
        o_verdict.error_kind = ERR_NONE;
        pf                   = i_state.pipe_fault | i_state.pipe_wait;
        rf                   = i_state.redir_fault | (i_state.redir_kind != R_NONE);

        if (i_byte == CH_EOL) begin
            o_verdict.eol = 1'b1;
            if (quoted) begin
                o_verdict.error_kind = ERR_QUOTE;
            end else if (pf) begin
                o_verdict.error_kind = ERR_PIPE;
            end else if (rf) begin
                o_verdict.error_kind = ERR_REDIR;
            end
            o_verdict.line_ok = (o_verdict.error_kind == ERR_NONE);
            o_next = '0;
        end else begin
            // pipe checks
            if (!blank) begin
                if (i_state.pipe_wait) begin
                    if (i_byte == CH_PIPE) begin
                        o_next.pipe_fault = 1'b1;
                    end
                    o_next.pipe_wait = 1'b0;
                end
                if (i_byte == CH_PIPE && !quoted) begin
                    if (!i_state.seen_text) begin
                        o_next.pipe_fault = 1'b1;
                    end
                    o_next.pipe_wait = 1'b1;
                end
                o_next.seen_text = 1'b1;
            end

            // redirection run: extend, gap, close, or open
            if (i_state.redir_kind != R_NONE) begin
                if (i_byte == run_ch && !i_state.redir_gap) begin
                    if (i_state.redir_count != RUN_SAT) begin
                        o_next.redir_count = i_state.redir_count + 2'd1;
                    end
                    if (o_next.redir_count > RUN_MAX) begin
                        o_next.redir_fault = 1'b1;
                    end
                end else if (blank) begin
                    o_next.redir_gap = 1'b1;
                end else begin
                    if (i_byte == CH_PIPE || i_byte == CH_LT || i_byte == CH_GT) begin
                        o_next.redir_fault = 1'b1;
                    end
                    o_next.redir_kind  = R_NONE;
                    o_next.redir_count = 2'd0;
                    o_next.redir_gap   = 1'b0;
                end
            end
            if (o_next.redir_kind == R_NONE && !quoted &&
                (i_byte == CH_LT || i_byte == CH_GT)) begin
                o_next.redir_kind  = (i_byte == CH_LT) ? R_IN : R_OUT;
                o_next.redir_count = 2'd1;
                o_next.redir_gap   = 1'b0;
            end

            // quote tracking
            if (i_byte == CH_SQ || i_byte == CH_DQ) begin
                if (i_state.quote_mode == Q_NONE) begin
                    o_next.quote_mode = (i_byte == CH_SQ) ? Q_SINGLE : Q_DOUBLE;
                end else if (i_state.quote_mode == ((i_byte == CH_SQ) ? Q_SINGLE : Q_DOUBLE)) begin
                    o_next.quote_mode = Q_NONE;
                end
            end
        end
    end

endmodule
